### rtl/swmf_pkg.sv
package swmf_pkg;

    localparam int CFG_DATA_W = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_OUT_W = 7;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IGNORE_NEG = 2'd2;

    localparam logic [CFG_DATA_W-1:0] WINDOW_SIZE_RESET = 7'd8;
    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 7'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CNT_RD,
        ST_CNT_CK,
        ST_DROP_CHK,
        ST_DROP_RD,
        ST_DEL_RD,
        ST_DEL_CK,
        ST_SH_RD,
        ST_SH_WR,
        ST_MODE_RD,
        ST_MODE_CK,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_TAB_RD,
        OP_TAB_RD_K1,
        OP_NEW,
        OP_INC,
        OP_NEXT,
        OP_CLR_I,
        OP_RING_RD,
        OP_DROP,
        OP_DEC,
        OP_SH_START,
        OP_SH_WR,
        OP_SH_END,
        OP_MODE_CK,
        OP_LOAD
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic i_end;
        logic match;
        logic cnt_gt1;
        logic need_drop;
        logic k_more;
        logic out_free;
    } status_t;

endpackage

### rtl/swmf_ram.sv
module swmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/swmf_ctrl.sv
module swmf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  swmf_pkg::status_t status,
    output swmf_pkg::cmd_t    cmd
);

    swmf_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swmf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op = swmf_pkg::OP_NONE;
        in_ready = 1'b0;
        case (state_reg)
            swmf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = swmf_pkg::OP_ACCEPT;
                    state_next = swmf_pkg::ST_CNT_RD;
                end
            end
            swmf_pkg::ST_CNT_RD:
            begin
                if (status.i_end)
                begin
                    cmd.op = swmf_pkg::OP_NEW;
                    state_next = swmf_pkg::ST_DROP_CHK;
                end
                else
                begin
                    cmd.op = swmf_pkg::OP_TAB_RD;
                    state_next = swmf_pkg::ST_CNT_CK;
                end
            end
            swmf_pkg::ST_CNT_CK:
            begin
                if (status.match)
                begin
                    cmd.op = swmf_pkg::OP_INC;
                    state_next = swmf_pkg::ST_DROP_CHK;
                end
                else
                begin
                    cmd.op = swmf_pkg::OP_NEXT;
                    state_next = swmf_pkg::ST_CNT_RD;
                end
            end
            swmf_pkg::ST_DROP_CHK:
            begin
                if (status.need_drop)
                begin
                    cmd.op = swmf_pkg::OP_RING_RD;
                    state_next = swmf_pkg::ST_DROP_RD;
                end
                else
                begin
                    state_next = swmf_pkg::ST_MODE_RD;
                end
            end
            swmf_pkg::ST_DROP_RD:
            begin
                cmd.op = swmf_pkg::OP_DROP;
                state_next = swmf_pkg::ST_DEL_RD;
            end
            swmf_pkg::ST_DEL_RD:
            begin
                if (status.i_end)
                begin
                    cmd.op = swmf_pkg::OP_CLR_I;
                    state_next = swmf_pkg::ST_MODE_RD;
                end
                else
                begin
                    cmd.op = swmf_pkg::OP_TAB_RD;
                    state_next = swmf_pkg::ST_DEL_CK;
                end
            end
            swmf_pkg::ST_DEL_CK:
            begin
                if (!status.match)
                begin
                    cmd.op = swmf_pkg::OP_NEXT;
                    state_next = swmf_pkg::ST_DEL_RD;
                end
                else if (status.cnt_gt1)
                begin
                    cmd.op = swmf_pkg::OP_DEC;
                    state_next = swmf_pkg::ST_MODE_RD;
                end
                else
                begin
                    cmd.op = swmf_pkg::OP_SH_START;
                    state_next = swmf_pkg::ST_SH_RD;
                end
            end
            swmf_pkg::ST_SH_RD:
            begin
                if (status.k_more)
                begin
                    cmd.op = swmf_pkg::OP_TAB_RD_K1;
                    state_next = swmf_pkg::ST_SH_WR;
                end
                else
                begin
                    cmd.op = swmf_pkg::OP_SH_END;
                    state_next = swmf_pkg::ST_MODE_RD;
                end
            end
            swmf_pkg::ST_SH_WR:
            begin
                cmd.op = swmf_pkg::OP_SH_WR;
                state_next = swmf_pkg::ST_SH_RD;
            end
            swmf_pkg::ST_MODE_RD:
            begin
                if (status.i_end)
                begin
                    state_next = swmf_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.op = swmf_pkg::OP_TAB_RD;
                    state_next = swmf_pkg::ST_MODE_CK;
                end
            end
            swmf_pkg::ST_MODE_CK:
            begin
                cmd.op = swmf_pkg::OP_MODE_CK;
                state_next = swmf_pkg::ST_MODE_RD;
            end
            swmf_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.op = swmf_pkg::OP_LOAD;
                    state_next = swmf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swmf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/swmf_datapath.sv
module swmf_datapath #(
    parameter int WINDOW_MAX = 64,
    parameter int ID_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [swmf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [swmf_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [swmf_pkg::SAMPLE_W-1:0]        sample_id,
    input  swmf_pkg::cmd_t                       cmd,
    output swmf_pkg::status_t                    status,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 found,
    output logic [swmf_pkg::SAMPLE_W-1:0]        chosen_id,
    output logic [swmf_pkg::COUNT_OUT_W-1:0]     chosen_count
);

    localparam int SLOTS = WINDOW_MAX + 1;
    localparam int AW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int TW = ID_BITS + CW;
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    // Configuration registers.
    logic [swmf_pkg::CFG_DATA_W-1:0] window_size_reg;
    logic [swmf_pkg::CFG_DATA_W-1:0] threshold_reg;
    logic                            ignore_neg_reg;

    // Control state.
    logic [AW-1:0] head_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] used_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] k_reg;
    logic          out_valid_reg;
    logic          out_valid_next;

    // Payload registers.
    logic [ID_BITS-1:0] key_reg;
    logic [CW-1:0]      best_reg;
    logic [ID_BITS-1:0] best_id_reg;
    logic               hit_reg;
    logic               found_reg;
    logic [ID_BITS-1:0] chosen_id_reg;
    logic [CW-1:0]      chosen_count_reg;

    // Memories.
    logic               ring_we;
    logic [AW-1:0]      ring_waddr;
    logic [AW-1:0]      ring_raddr;
    logic [ID_BITS-1:0] ring_rdata;
    logic               tab_we;
    logic [AW-1:0]      tab_waddr;
    logic [TW-1:0]      tab_wdata;
    logic [AW-1:0]      tab_raddr;
    logic [TW-1:0]      tab_rdata;

    logic [31:0]        sample_ext;
    logic [ID_BITS-1:0] sample_val;
    logic [ID_BITS-1:0] rd_id;
    logic [CW-1:0]      rd_cnt;
    logic [CW:0]        ring_sum;
    logic [31:0]        size_ext;
    logic [CW-1:0]      size_val;
    logic [CW-1:0]      k_plus1;
    logic               qualifies;
    logic [31:0]        best_ext;

    assign sample_ext = {{(32 - swmf_pkg::SAMPLE_W){1'b0}}, sample_id};
    assign sample_val = sample_ext[ID_BITS-1:0];
    assign rd_id = tab_rdata[TW-1:CW];
    assign rd_cnt = tab_rdata[CW-1:0];
    assign k_plus1 = k_reg + ONE_C;

    // The write slot is head plus fill, which stays below twice the ring size.
    assign ring_sum = {1'b0, CW'(head_reg)} + {1'b0, fill_reg};
    assign ring_waddr = (ring_sum >= {1'b0, SLOTS_C}) ? AW'(ring_sum - {1'b0, SLOTS_C})
                                                      : AW'(ring_sum);
    assign ring_raddr = head_reg;
    assign ring_we = (cmd.op == swmf_pkg::OP_ACCEPT) && (fill_reg < SLOTS_C);

    assign size_ext = (32'(window_size_reg) > 32'(WINDOW_MAX)) ? 32'(WINDOW_MAX)
                                                               : 32'(window_size_reg);
    assign size_val = size_ext[CW-1:0];

    assign qualifies = (32'(rd_cnt) >= 32'(threshold_reg)) && (rd_cnt > best_reg)
                       && !(ignore_neg_reg && rd_id[ID_BITS-1]);

    assign status.i_end = (i_reg == used_reg);
    assign status.match = (rd_id == key_reg);
    assign status.cnt_gt1 = (rd_cnt > ONE_C);
    assign status.need_drop = (fill_reg > size_val) && (fill_reg != '0);
    assign status.k_more = (k_plus1 < used_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.op == swmf_pkg::OP_LOAD)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        tab_we = 1'b0;
        tab_waddr = i_reg[AW-1:0];
        tab_wdata = {rd_id, rd_cnt};
        tab_raddr = i_reg[AW-1:0];
        case (cmd.op)
            swmf_pkg::OP_NEW:
            begin
                tab_we = (used_reg < SLOTS_C);
                tab_waddr = used_reg[AW-1:0];
                tab_wdata = {key_reg, ONE_C};
            end
            swmf_pkg::OP_INC:
            begin
                tab_we = 1'b1;
                tab_wdata = {rd_id, rd_cnt + ONE_C};
            end
            swmf_pkg::OP_DEC:
            begin
                tab_we = 1'b1;
                tab_wdata = {rd_id, rd_cnt - ONE_C};
            end
            swmf_pkg::OP_TAB_RD_K1:
            begin
                tab_raddr = k_plus1[AW-1:0];
            end
            swmf_pkg::OP_SH_WR:
            begin
                tab_we = 1'b1;
                tab_waddr = k_reg[AW-1:0];
            end
            default:
            begin
                tab_we = 1'b0;
            end
        endcase
    end

    swmf_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (SLOTS)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (sample_val),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    swmf_ram #(
        .WIDTH (TW),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= swmf_pkg::WINDOW_SIZE_RESET;
            threshold_reg <= swmf_pkg::THRESHOLD_RESET;
            ignore_neg_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                swmf_pkg::REG_WINDOW_SIZE: window_size_reg <= cfg_data;
                swmf_pkg::REG_THRESHOLD:   threshold_reg <= cfg_data;
                swmf_pkg::REG_IGNORE_NEG:  ignore_neg_reg <= cfg_data[0];
                default:                   ignore_neg_reg <= ignore_neg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
            used_reg <= '0;
            i_reg <= '0;
            k_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            case (cmd.op)
                swmf_pkg::OP_ACCEPT:
                begin
                    i_reg <= '0;
                    if (fill_reg < SLOTS_C)
                    begin
                        fill_reg <= fill_reg + ONE_C;
                    end
                end
                swmf_pkg::OP_NEW:
                begin
                    i_reg <= '0;
                    if (used_reg < SLOTS_C)
                    begin
                        used_reg <= used_reg + ONE_C;
                    end
                end
                swmf_pkg::OP_INC, swmf_pkg::OP_DEC, swmf_pkg::OP_CLR_I:
                begin
                    i_reg <= '0;
                end
                swmf_pkg::OP_NEXT, swmf_pkg::OP_MODE_CK:
                begin
                    i_reg <= i_reg + ONE_C;
                end
                swmf_pkg::OP_DROP:
                begin
                    i_reg <= '0;
                    fill_reg <= fill_reg - ONE_C;
                    head_reg <= (head_reg == AW'(SLOTS - 1)) ? '0 : head_reg + AW'(1);
                end
                swmf_pkg::OP_SH_START:
                begin
                    k_reg <= i_reg;
                end
                swmf_pkg::OP_SH_WR:
                begin
                    k_reg <= k_plus1;
                end
                swmf_pkg::OP_SH_END:
                begin
                    i_reg <= '0;
                    used_reg <= used_reg - ONE_C;
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            swmf_pkg::OP_ACCEPT:
            begin
                key_reg <= sample_val;
                best_reg <= '0;
                best_id_reg <= '0;
                hit_reg <= 1'b0;
            end
            swmf_pkg::OP_DROP:
            begin
                key_reg <= ring_rdata;
            end
            swmf_pkg::OP_MODE_CK:
            begin
                if (qualifies)
                begin
                    best_reg <= rd_cnt;
                    best_id_reg <= rd_id;
                    hit_reg <= 1'b1;
                end
            end
            swmf_pkg::OP_LOAD:
            begin
                found_reg <= hit_reg;
                chosen_id_reg <= best_id_reg;
                chosen_count_reg <= best_reg;
            end
            default:
            begin
                key_reg <= key_reg;
            end
        endcase
    end

    assign best_ext = 32'(chosen_id_reg);
    assign out_valid = out_valid_reg;
    assign found = found_reg;
    assign chosen_id = best_ext[swmf_pkg::SAMPLE_W-1:0];
    assign chosen_count = swmf_pkg::COUNT_OUT_W'(chosen_count_reg);

endmodule

### rtl/sliding_window_mode_filter.sv
// Sliding-window mode filter.
// Samples arrive on the in_valid/in_ready channel, one ID per transfer. Every
// accepted sample yields exactly one result transfer on out_valid/out_ready,
// carrying found, chosen_id and chosen_count for the window after that sample.
// Configuration (window_size, threshold, ignore_negative) is written through
// cfg_write/cfg_index/cfg_data while the block is idle.
// Each sample runs through a sequencer over the count table, which sits in a
// RAM with a registered read, so every table entry visited takes a read state
// and a check state. The steps in order: accept the sample, count it by
// scanning the table for its ID or appending it, check whether the window is
// too full, if so read the oldest sample and scan for its entry, decrement it
// or remove it by moving the entries behind it up, pick the mode over the
// table, and load the result.
// Reset empties the window and the table and restores window_size 8,
// threshold 1 and ignore_negative 0; no clearing pass is needed.
// The result sits in an output register; a new sample is taken as soon as
// the previous one is finished, and if the receiver stalls, the next result
// waits at the end of its computation until the output register frees up.
module sliding_window_mode_filter #(
    parameter int WINDOW_MAX = 64,
    parameter int ID_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [swmf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [swmf_pkg::SAMPLE_W-1:0]    sample_id,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [swmf_pkg::SAMPLE_W-1:0]    chosen_id,
    output logic [swmf_pkg::COUNT_OUT_W-1:0] chosen_count
);

    swmf_pkg::cmd_t    cmd;
    swmf_pkg::status_t status;

    swmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    swmf_datapath #(
        .WINDOW_MAX (WINDOW_MAX),
        .ID_BITS    (ID_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_id    (sample_id),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .chosen_id    (chosen_id),
        .chosen_count (chosen_count)
    );

endmodule

### verif/swmf_checker.sv
`timescale 1ns / 100ps

module swmf_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [swmf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [swmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [swmf_pkg::SAMPLE_W-1:0]    sample_id,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             found,
    input  logic [swmf_pkg::SAMPLE_W-1:0]    chosen_id,
    input  logic [swmf_pkg::COUNT_OUT_W-1:0] chosen_count,
    output int                               mismatches,
    output int                               pending
);

    localparam int SLOTS = 65;
    localparam int WMAX = 64;
    localparam int DUE_DEPTH = 16;

    typedef struct packed {
        logic        found;
        logic [15:0] id;
        logic [6:0]  count;
    } mode_t;

    logic [15:0] ring [SLOTS];
    int          ring_head;
    int          ring_fill;
    logic [15:0] ids [SLOTS];
    int          counts [SLOTS];
    int          used;
    int          win_size;
    int          thresh;
    logic        skip_neg;
    mode_t       modes_due [DUE_DEPTH];
    int          due_rd;
    int          due_wr;
    int          due_cnt;

    assign pending = due_cnt;

    function automatic mode_t track_sample(input logic [15:0] v);
        int    lim;
        int    i;
        int    k;
        int    best;
        bit    seen;
        logic [15:0] old;
        mode_t r;
        lim = (win_size > WMAX) ? WMAX : win_size;
        seen = 0;
        if (ring_fill < SLOTS)
        begin
            ring[(ring_head + ring_fill) % SLOTS] = v;
            ring_fill++;
        end
        for (i = 0; i < used; i++)
        begin
            if (ids[i] == v)
            begin
                counts[i]++;
                seen = 1;
                break;
            end
        end
        if (!seen && used < SLOTS)
        begin
            ids[used] = v;
            counts[used] = 1;
            used++;
        end
        if (ring_fill > lim && ring_fill > 0)
        begin
            old = ring[ring_head];
            ring_head = (ring_head + 1) % SLOTS;
            ring_fill--;
            for (i = 0; i < used; i++)
            begin
                if (ids[i] != old)
                    continue;
                if (counts[i] > 1)
                    counts[i]--;
                else
                begin
                    for (k = i; k + 1 < used; k++)
                    begin
                        ids[k] = ids[k + 1];
                        counts[k] = counts[k + 1];
                    end
                    used--;
                    ids[used] = '0;
                    counts[used] = 0;
                end
                break;
            end
        end
        best = 0;
        r = '0;
        for (i = 0; i < used; i++)
        begin
            if (counts[i] >= thresh && counts[i] > best && !(skip_neg && ids[i][15]))
            begin
                best = counts[i];
                r.found = 1'b1;
                r.id = ids[i];
                r.count = 7'(best);
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mode_t want;
        if (!rst_n)
        begin
            ring_head = 0;
            ring_fill = 0;
            used = 0;
            for (int i = 0; i < SLOTS; i++)
            begin
                counts[i] = 0;
                ids[i] = '0;
            end
            win_size = 8;
            thresh = 1;
            skip_neg = 1'b0;
            due_rd = 0;
            due_wr = 0;
            due_cnt = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    swmf_pkg::REG_WINDOW_SIZE: win_size = cfg_data;
                    swmf_pkg::REG_THRESHOLD:   thresh = cfg_data;
                    swmf_pkg::REG_IGNORE_NEG:  skip_neg = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (due_cnt == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with nothing expected", $time);
                end
                else
                begin
                    want = modes_due[due_rd];
                    due_rd = (due_rd + 1) % DUE_DEPTH;
                    due_cnt--;
                    if (found !== want.found || chosen_id !== want.id
                        || chosen_count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: expected found=%0b id=%h count=%0d, got %b %h %0d",
                                     $time, want.found, want.id, want.count,
                                     found, chosen_id, chosen_count);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                modes_due[due_wr] = track_sample(sample_id);
                due_wr = (due_wr + 1) % DUE_DEPTH;
                due_cnt++;
            end
        end
    end
endmodule

### verif/tb_sliding_window_mode_filter.sv
`timescale 1ns / 100ps

module tb_sliding_window_mode_filter;

    localparam int STALL_LIMIT = 20000;
    localparam logic [swmf_pkg::CFG_INDEX_W-1:0] UNMAPPED_REG = 2'd3;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [swmf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [swmf_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_ready;
    logic [swmf_pkg::SAMPLE_W-1:0]    sample_id;
    logic                             out_valid;
    logic                             out_ready;
    logic                             found;
    logic [swmf_pkg::SAMPLE_W-1:0]    chosen_id;
    logic [swmf_pkg::COUNT_OUT_W-1:0] chosen_count;
    int                               mismatches;
    int                               pending;
    int                               idle_cycles;
    logic [15:0]                      pool [8];
    bit                               stall_free;

    sliding_window_mode_filter u_dut (.*);

    swmf_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int gap_len();
        if (stall_free)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // The watchdog restarts whenever a transfer happens on either channel.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_free || $urandom_range(0, 3) != 0)
                out_ready = 1'b1;
            else
            begin
                out_ready = 1'b0;
                repeat (gap_len()) @(negedge clk);
            end
        end
    end

    // in_ready only changes at rising edges, so its value at a falling edge
    // tells whether the next rising edge takes the transfer.
    task automatic send_sample(input logic [15:0] v);
        repeat (gap_len()) @(negedge clk);
        in_valid = 1'b1;
        sample_id = v;
        while (!in_ready)
            @(negedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [swmf_pkg::CFG_INDEX_W-1:0] idx, input int val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = swmf_pkg::CFG_DATA_W'(val);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic reshuffle_pool();
        for (int i = 0; i < 8; i++)
            pool[i] = 16'($urandom);
        pool[0][15] = 1'b1;
        pool[1][15] = 1'b0;
    endtask

    // Each phase waits for all results first, then makes its settings while idle
    // and sends samples drawn mostly from a freshly shuffled pool of IDs.
    task automatic run_phase(input int ws, input int th, input bit neg, input int n);
        drain();
        write_reg(swmf_pkg::REG_WINDOW_SIZE, ws);
        write_reg(swmf_pkg::REG_THRESHOLD, th);
        write_reg(swmf_pkg::REG_IGNORE_NEG, neg);
        reshuffle_pool();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_sample(16'($urandom));
            else
                send_sample(pool[$urandom_range(0, 3 + $urandom_range(0, 4))]);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        sample_id = '0;
        stall_free = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extreme IDs and ties under the reset settings, then extreme settings and an unmapped register.
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        drain();
        write_reg(swmf_pkg::REG_IGNORE_NEG, 1);
        send_sample(16'h8000);
        send_sample(16'h8000);
        drain();
        write_reg(UNMAPPED_REG, 7'h55);
        write_reg(swmf_pkg::REG_THRESHOLD, 0);
        send_sample(16'h0001);
        drain();
        write_reg(swmf_pkg::REG_THRESHOLD, 127);
        send_sample(16'h0001);
        drain();
        write_reg(swmf_pkg::REG_WINDOW_SIZE, 0);
        send_sample(16'h1234);
        send_sample(16'h1234);
        drain();
        write_reg(swmf_pkg::REG_WINDOW_SIZE, 127);
        write_reg(swmf_pkg::REG_THRESHOLD, 2);
        send_sample(16'h1234);
        send_sample(16'h1234);

        run_phase(127, 1, 0, 150);
        run_phase(64, 64, 0, 150);
        run_phase(1, 1, 1, 100);
        run_phase(8, 3, 1, 200);
        stall_free = 1'b1;
        run_phase(16, 0, 0, 150);
        stall_free = 1'b0;
        run_phase(5, 2, 0, 200);
        run_phase(32, 4, 1, 200);
        run_phase(2, 1, 0, 150);

        drain();
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### sliding_window_mode_filter.f
rtl/swmf_pkg.sv
rtl/swmf_ram.sv
rtl/swmf_ctrl.sv
rtl/swmf_datapath.sv
rtl/sliding_window_mode_filter.sv
verif/swmf_checker.sv
verif/tb_sliding_window_mode_filter.sv
